// ----- rtl/hrsi_pkg.sv -----
`default_nettype none

package hrsi_pkg;

    localparam int unsigned TIME_W  = 40;
    localparam int unsigned ALU_W   = TIME_W + 1;
    localparam int unsigned DELAY_W = 20;
    localparam int unsigned TOL_W   = 16;
    localparam int unsigned NWIRES  = 4;

    localparam logic [DELAY_W-1:0] DELAY_RST   = 20'd337500;
    localparam logic [TOL_W-1:0]   TOL_RST     = 16'd1000;
    localparam logic [3:0]         PRESENT_RST = 4'hf;

    localparam logic [1:0] WIRE_COMP  = 2'd0;
    localparam logic [1:0] WIRE_HEAT2 = 2'd1;
    localparam logic [1:0] WIRE_REV   = 2'd2;
    localparam logic [1:0] WIRE_FAN   = 2'd3;

    localparam logic [1:0] REG_DELAY   = 2'd0;
    localparam logic [1:0] REG_TOL     = 2'd1;
    localparam logic [1:0] REG_PRESENT = 2'd2;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef enum logic [1:0] {
        TRI_UNKNOWN = 2'd0,
        TRI_OFF     = 2'd1,
        TRI_ON      = 2'd2
    } t_tri;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LOCKOUT     = 3'd1,
        ST_REV_REFUSED = 3'd2,
        ST_FAN_COMP    = 3'd3,
        ST_FAN_HEAT2   = 3'd4,
        ST_BAD_WIRE    = 3'd5
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CMP,
        S_EV0,
        S_EV1,
        S_REPLY
    } t_seq;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [TOL_W-1:0]   tol;
        logic [3:0]         present;
    } t_cfg;

    typedef struct packed {
        logic         kind;
        logic [3:0]   wire_id;
        logic         wire_on;
        logic         accepted;
        t_status      status;
        logic         last;
        t_tri [3:0]   wst;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/hrsi_alu.sv -----
`default_nettype none

module hrsi_alu
    import hrsi_pkg::*;
(
    input  t_alu_op          i_op,
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    output logic [ALU_W-1:0] o_res,
    output logic             o_msb
);

    logic [ALU_W:0] b_eff;
    logic [ALU_W:0] full;

    // For a subtract the top bit of the widened result is set exactly when a < b.
    assign b_eff = (i_op == ALU_SUB) ? ~{1'b0, i_b} : {1'b0, i_b};
    assign full  = {1'b0, i_a} + b_eff + {{ALU_W{1'b0}}, (i_op == ALU_SUB)};
    assign o_res = full[ALU_W-1:0];
    assign o_msb = full[ALU_W];

endmodule

`default_nettype wire

// ----- rtl/hrsi_ctrl.sv -----
`default_nettype none

module hrsi_ctrl
    import hrsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3:0]        i_req_wire,
    input  logic              i_req_connect,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_res
);

    t_seq              r_seq, n_seq;
    logic [3:0]        r_wire;
    logic              r_on;
    logic [TIME_W-1:0] r_now;
    logic [ALU_W-1:0]  r_acc, n_acc;
    logic [1:0]        r_ev_v, n_ev_v;
    logic [1:0][1:0]   r_ev_wire, n_ev_wire;
    logic [1:0]        r_ev_on, n_ev_on;
    t_status           r_status, n_status;
    t_tri [3:0]        r_wst, n_wst;
    logic [TIME_W-1:0] r_ct [NWIRES];
    logic [TIME_W-1:0] n_ct [NWIRES];
    t_result           r_out, n_out;
    logic              r_ovalid, n_ovalid;

    t_alu_op          alu_op;
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_msb;
    logic             is_rev;
    logic [1:0]       ct_idx;
    logic [1:0]       w2;
    t_tri             want;
    logic             out_free;
    logic             slot;
    logic [1:0]       dw;
    logic             don;
    t_tri             dval;

    assign is_rev   = (r_wire == {2'b00, WIRE_REV});
    assign ct_idx   = is_rev ? WIRE_COMP : {1'b0, r_wire[0]};
    assign w2       = r_wire[1:0];
    assign want     = r_on ? TRI_ON : TRI_OFF;
    assign out_free = !r_ovalid || i_ready;
    assign slot     = (r_seq == S_EV1);
    assign dw       = r_ev_wire[slot];
    assign don      = r_ev_on[slot];
    assign dval     = don ? TRI_ON : TRI_OFF;

    hrsi_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_msb (alu_msb)
    );

    always_comb begin
        n_seq     = r_seq;
        n_acc     = r_acc;
        n_ev_v    = r_ev_v;
        n_ev_wire = r_ev_wire;
        n_ev_on   = r_ev_on;
        n_status  = r_status;
        n_wst     = r_wst;
        n_ct      = r_ct;
        n_out     = r_out;
        n_ovalid  = r_ovalid && !i_ready;
        alu_op    = ALU_ADD;
        alu_a     = {1'b0, r_ct[ct_idx]};
        alu_b     = is_rev ? {{(ALU_W-TOL_W){1'b0}}, i_cfg.tol}
                           : {{(ALU_W-DELAY_W){1'b0}}, i_cfg.delay};
        unique case (r_seq)
            S_IDLE: begin
                if (i_valid) begin
                    n_seq = S_ADD;
                end
            end
            S_ADD: begin
                n_acc = alu_res;
                n_seq = S_CMP;
            end
            S_CMP: begin
                alu_op    = ALU_SUB;
                alu_a     = is_rev ? r_acc : {1'b0, r_now};
                alu_b     = is_rev ? {1'b0, r_now} : r_acc;
                n_ev_v    = 2'b00;
                n_ev_wire = '0;
                n_ev_on   = 2'b00;
                n_status  = ST_OK;
                n_seq     = S_EV0;
                if (r_wire[3:2] != 2'b00) begin
                    n_status = ST_BAD_WIRE;
                end else begin
                    unique case (w2)
                        WIRE_COMP, WIRE_HEAT2: begin
                            if (r_on && r_wst[w2] != TRI_ON && alu_msb) begin
                                n_status = ST_LOCKOUT;
                            end else begin
                                if (r_on && r_wst[w2] != TRI_ON && i_cfg.present[WIRE_FAN]
                                    && r_wst[WIRE_FAN] != TRI_ON) begin
                                    n_ev_v[0]    = 1'b1;
                                    n_ev_wire[0] = WIRE_FAN;
                                    n_ev_on[0]   = 1'b1;
                                end
                                if (i_cfg.present[w2]) begin
                                    n_ev_v[1]    = 1'b1;
                                    n_ev_wire[1] = w2;
                                    n_ev_on[1]   = r_on;
                                end else begin
                                    n_status = ST_BAD_WIRE;
                                end
                            end
                        end
                        WIRE_REV: begin
                            if (r_wst[WIRE_COMP] != TRI_OFF && r_wst[WIRE_REV] != want
                                && alu_msb) begin
                                n_status = ST_REV_REFUSED;
                                if (i_cfg.present[WIRE_COMP]) begin
                                    n_ev_v[0]    = 1'b1;
                                    n_ev_wire[0] = WIRE_COMP;
                                    n_ev_on[0]   = 1'b0;
                                end
                            end else if (i_cfg.present[WIRE_REV]) begin
                                n_ev_v[1]    = 1'b1;
                                n_ev_wire[1] = WIRE_REV;
                                n_ev_on[1]   = r_on;
                            end else begin
                                n_status = ST_BAD_WIRE;
                            end
                        end
                        WIRE_FAN: begin
                            if (!r_on && r_wst[WIRE_COMP] != TRI_OFF) begin
                                n_status = ST_FAN_COMP;
                            end else if (!r_on && i_cfg.present[WIRE_HEAT2]
                                         && r_wst[WIRE_HEAT2] != TRI_OFF) begin
                                n_status = ST_FAN_HEAT2;
                            end else if (i_cfg.present[WIRE_FAN]) begin
                                n_ev_v[1]    = 1'b1;
                                n_ev_wire[1] = WIRE_FAN;
                                n_ev_on[1]   = r_on;
                            end else begin
                                n_status = ST_BAD_WIRE;
                            end
                        end
                    endcase
                end
            end
            S_EV0, S_EV1: begin
                if (!r_ev_v[slot]) begin
                    n_seq = slot ? S_REPLY : S_EV1;
                end else if (out_free) begin
                    n_wst[dw] = dval;
                    if (r_wst[dw] != dval) begin
                        n_ct[dw] = r_now;
                    end
                    n_ovalid       = 1'b1;
                    n_out.kind     = KIND_EVENT;
                    n_out.wire_id  = {2'b00, dw};
                    n_out.wire_on  = don;
                    n_out.accepted = 1'b0;
                    n_out.status   = ST_OK;
                    n_out.last     = 1'b0;
                    n_out.wst      = n_wst;
                    n_seq          = slot ? S_REPLY : S_EV1;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_ovalid       = 1'b1;
                    n_out.kind     = KIND_REPLY;
                    n_out.wire_id  = r_wire;
                    n_out.wire_on  = r_on;
                    n_out.accepted = (r_status == ST_OK);
                    n_out.status   = r_status;
                    n_out.last     = 1'b1;
                    n_out.wst      = r_wst;
                    n_seq          = S_IDLE;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wst    <= {TRI_UNKNOWN, TRI_UNKNOWN, TRI_UNKNOWN, TRI_UNKNOWN};
            for (int i = 0; i < NWIRES; i++) begin
                r_ct[i] <= '0;
            end
        end else begin
            r_seq    <= n_seq;
            r_ovalid <= n_ovalid;
            r_wst    <= n_wst;
            r_ct     <= n_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_seq == S_IDLE && i_valid) begin
            r_wire <= i_req_wire;
            r_on   <= i_req_connect;
            r_now  <= i_now_ms;
        end
        r_acc     <= n_acc;
        r_ev_v    <= n_ev_v;
        r_ev_wire <= n_ev_wire;
        r_ev_on   <= n_ev_on;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_ready = (r_seq == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_res   = r_out;

`ifndef ASSERT_OFF
    a_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.kind == KIND_EVENT |-> !r_out.accepted && !r_out.last)
        else $error("event word carries reply fields");
    a_reply_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.kind == KIND_REPLY |-> r_out.accepted == (r_out.status == ST_OK))
        else $error("reply accepted flag disagrees with status");
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_seq == S_ADD)
        else $error("accepted word did not start the sequencer");
    a_ct_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ct[WIRE_COMP] != $past(r_ct[WIRE_COMP]) |-> r_wst[WIRE_COMP] != $past(r_wst[WIRE_COMP]))
        else $error("compressor change time moved without a state change");
`endif

endmodule

`default_nettype wire

// ----- rtl/hvac_relay_safety_interlock.sv -----
`default_nettype none
// A request word is taken only while the sequencer is idle. It then passes through an add
// step and a compare step, both on the shared 41-bit adder, then the event states EV0 and EV1
// and the reply state, which registers the reply word that ends the run.
// A new request is not taken until the reply has gone to the output register and the sequencer
// is idle again; an event or reply that waits for the output register to free up stalls the run.
// Reset is synchronous and active low: relays read unknown, change times and configuration reset.

module hvac_relay_safety_interlock
    import hrsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3:0]        i_req_wire,
    input  logic              i_req_connect,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [3:0]        o_wire_id,
    output logic              o_wire_on,
    output logic              o_accepted,
    output logic [2:0]        o_status,
    output logic              o_last_of_run,
    output logic [1:0]        o_compressor_state,
    output logic [1:0]        o_heat2_state,
    output logic [1:0]        o_reversing_state,
    output logic [1:0]        o_fan_state
);

    t_cfg    r_cfg;
    t_result res;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay   <= DELAY_RST;
            r_cfg.tol     <= TOL_RST;
            r_cfg.present <= PRESENT_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_DELAY:   r_cfg.delay   <= pwdata[DELAY_W-1:0];
                REG_TOL:     r_cfg.tol     <= pwdata[TOL_W-1:0];
                REG_PRESENT: r_cfg.present <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DELAY:   prdata = {{(32-DELAY_W){1'b0}}, r_cfg.delay};
            REG_TOL:     prdata = {{(32-TOL_W){1'b0}}, r_cfg.tol};
            REG_PRESENT: prdata = {28'd0, r_cfg.present};
            default:     prdata = 32'd0;
        endcase
    end

    hrsi_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_wire    (i_req_wire),
        .i_req_connect (i_req_connect),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_res         (res)
    );

    assign o_kind             = res.kind;
    assign o_wire_id          = res.wire_id;
    assign o_wire_on          = res.wire_on;
    assign o_accepted         = res.accepted;
    assign o_status           = res.status;
    assign o_last_of_run      = res.last;
    assign o_compressor_state = res.wst[WIRE_COMP];
    assign o_heat2_state      = res.wst[WIRE_HEAT2];
    assign o_reversing_state  = res.wst[WIRE_REV];
    assign o_fan_state        = res.wst[WIRE_FAN];

endmodule

`default_nettype wire
